[src/script_op_return_scanner_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the output-script return-opcode scanner
// Clocked assertion wrappers for the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_OP_RETURN_SCANNER_ASSERT_SVH
`define SCRIPT_OP_RETURN_SCANNER_ASSERT_SVH

// Checked on every rising clock edge, switched off while reset is high.
`define SORS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SORS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/sors_pkg.sv]
// ----------------------------------------------------------------------------
// Script return-opcode scanner package
// Field widths, opcode constants, parser modes and transaction types.
// ----------------------------------------------------------------------------
package sors_pkg;

   localparam int SCRIPT_BYTE_W = 8;
   localparam int OFFSET_W      = 33;
   localparam int SKIP_W        = 32;
   localparam int LEN_LEFT_W    = 3;
   localparam int LEN_IDX_W     = 2;
   localparam int MODE_W        = 2;

   localparam int DEF_MAX_SCRIPT_BYTES = 65536;

   // Parser modes.
   localparam logic [MODE_W-1:0] MODE_OPCODE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LENGTH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SKIP   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DONE   = 2'd3;

   // Opcodes of interest.
   localparam logic [SCRIPT_BYTE_W-1:0] OP_RETURN   = 8'h6a;
   localparam logic [SCRIPT_BYTE_W-1:0] OP_PUSH1    = 8'd76;
   localparam logic [SCRIPT_BYTE_W-1:0] OP_PUSH2    = 8'd77;
   localparam logic [SCRIPT_BYTE_W-1:0] OP_PUSH4    = 8'd78;
   localparam logic [SCRIPT_BYTE_W-1:0] OP_FIRSTOTH = 8'd79;

   // Number of little-endian length bytes after each extended push opcode.
   localparam logic [LEN_LEFT_W-1:0] PUSH1_LEN_BYTES = 3'd1;
   localparam logic [LEN_LEFT_W-1:0] PUSH2_LEN_BYTES = 3'd2;
   localparam logic [LEN_LEFT_W-1:0] PUSH4_LEN_BYTES = 3'd4;

   typedef struct packed {
      logic [SCRIPT_BYTE_W-1:0] script_byte;
      logic                     is_last;
   } sors_req_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] offset;
      logic                truncated;
   } sors_rsp_type;

   // Parser state apart from the byte position, whose width is a parameter.
   typedef struct packed {
      logic [MODE_W-1:0]     parse_mode;
      logic [SKIP_W-1:0]     skip_remaining;
      logic [LEN_LEFT_W-1:0] length_bytes_left;
      logic [SKIP_W-1:0]     length_accumulator;
      logic [LEN_IDX_W-1:0]  length_byte_index;
   } sors_state_type;

   localparam sors_state_type STATE_RESET = '{
      parse_mode:         MODE_OPCODE,
      skip_remaining:     '0,
      length_bytes_left:  '0,
      length_accumulator: '0,
      length_byte_index:  '0
   };

endpackage

[src/script_op_return_scanner.sv]
// ----------------------------------------------------------------------------
// Script return-opcode scanner (top level)
// The result appears on rsp in the cycle after the final byte is taken.
// Throughput: one script byte per cycle; a last byte stalls on a held result.
// Reset (synchronous, active high) clears the parser and drops rsp_valid.
// ----------------------------------------------------------------------------
//
// Each transaction on the req channel carries one byte of an output script.
// The bytes are parsed as opcodes. Push opcodes are skipped along with their
// data: opcodes 1 to 75 give the data length directly, while the three
// extended push opcodes are followed by one, two or four little-endian length
// bytes. When the return opcode appears in opcode position, the parser stops
// and holds the offset just past it; the remaining bytes of the script are
// swallowed. On the final byte a single rsp transaction is issued and the
// parser returns to its reset state for the next script.
//
// The parser state sits in registers and is updated in one pass of short
// combinational logic per byte. The result is held in an output register,
// so bytes that are not the last of their script are taken even while an
// earlier result is still waiting to be collected; only a final byte has to
// wait for the output register to free up.
//
module script_op_return_scanner
   import sors_pkg::*;
#(
   parameter int MAX_SCRIPT_BYTES = DEF_MAX_SCRIPT_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sors_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sors_rsp_type rsp_data
);

   // Wide enough to hold the saturated byte count itself.
   localparam int POS_W = $clog2(MAX_SCRIPT_BYTES + 1);

   sors_state_type   state_ff;
   sors_state_type   state_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   sors_rsp_type     rsp_data_ff;
   sors_rsp_type     rsp_step;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             req_take;
   logic             out_free;

   // The output register is free when it is empty or being emptied now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_data.is_last || out_free;
   assign req_take  = req_valid && req_ready;

   sors_parse #(
      .MAX_SCRIPT_BYTES (MAX_SCRIPT_BYTES),
      .POS_W            (POS_W)
   ) u_parse (
      .state_cur (state_ff),
      .pos_cur   (pos_ff),
      .req       (req_data),
      .state_nxt (state_in),
      .pos_nxt   (pos_in),
      .rsp       (rsp_step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         pos_ff   <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   // A final byte loads a new result; otherwise a collected result leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take && req_data.is_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (req_take && req_data.is_last) begin
         rsp_data_ff <= rsp_step;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/sors_parse.sv]
// ----------------------------------------------------------------------------
// Script return-opcode scanner: parser step
// Next parser state for one script byte and the result for a final byte.
// ----------------------------------------------------------------------------
module sors_parse
   import sors_pkg::*;
#(
   parameter int MAX_SCRIPT_BYTES = DEF_MAX_SCRIPT_BYTES,
   parameter int POS_W            = $clog2(MAX_SCRIPT_BYTES + 1)
) (
   input  sors_state_type state_cur,
   input  logic [POS_W-1:0] pos_cur,
   input  sors_req_type   req,
   output sors_state_type state_nxt,
   output logic [POS_W-1:0] pos_nxt,
   output sors_rsp_type   rsp
);

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SCRIPT_BYTES);

   sors_state_type        st_upd;
   logic [POS_W-1:0]      pos_upd;
   logic [POS_W-1:0]      pos_cnt;
   logic [SKIP_W-1:0]     acc_upd;
   logic [LEN_LEFT_W-1:0] left_upd;
   logic [OFFSET_W-1:0]   extra;

   // The position saturates once the script grows past its maximum length.
   assign pos_cnt = (pos_cur < POS_MAX) ? pos_cur + POS_W'(1) : POS_MAX;

   assign acc_upd  = state_cur.length_accumulator |
                     (SKIP_W'(req.script_byte) << {state_cur.length_byte_index, 3'b000});
   assign left_upd = state_cur.length_bytes_left - LEN_LEFT_W'(1);

   always_comb begin
      st_upd  = state_cur;
      pos_upd = pos_cur;
      case (state_cur.parse_mode)
         MODE_OPCODE: begin
            pos_upd = pos_cnt;
            if (req.script_byte == OP_RETURN) begin
               st_upd.parse_mode = MODE_DONE;
            end else if (req.script_byte != '0 && req.script_byte < OP_PUSH1) begin
               st_upd.skip_remaining = SKIP_W'(req.script_byte);
               st_upd.parse_mode     = MODE_SKIP;
            end else if (req.script_byte >= OP_PUSH1 && req.script_byte < OP_FIRSTOTH) begin
               st_upd.length_bytes_left  = (req.script_byte == OP_PUSH1) ? PUSH1_LEN_BYTES :
                                           (req.script_byte == OP_PUSH2) ? PUSH2_LEN_BYTES :
                                                                           PUSH4_LEN_BYTES;
               st_upd.length_accumulator = '0;
               st_upd.length_byte_index  = '0;
               st_upd.parse_mode         = MODE_LENGTH;
            end
         end
         MODE_LENGTH: begin
            pos_upd                   = pos_cnt;
            st_upd.length_accumulator = acc_upd;
            st_upd.length_byte_index  = state_cur.length_byte_index + LEN_IDX_W'(1);
            st_upd.length_bytes_left  = left_upd;
            if (left_upd == '0) begin
               st_upd.skip_remaining = acc_upd;
               st_upd.parse_mode     = (acc_upd != '0) ? MODE_SKIP : MODE_OPCODE;
            end
         end
         MODE_SKIP: begin
            pos_upd               = pos_cnt;
            st_upd.skip_remaining = state_cur.skip_remaining - SKIP_W'(1);
            if (st_upd.skip_remaining == '0) begin
               st_upd.parse_mode = MODE_OPCODE;
            end
         end
         default: begin
            // Return already found: the position stays frozen.
         end
      endcase
   end

   // An unfinished length field or push counts towards the end position.
   always_comb begin
      case (st_upd.parse_mode)
         MODE_LENGTH: extra = OFFSET_W'(st_upd.length_bytes_left) +
                              OFFSET_W'(st_upd.length_accumulator);
         MODE_SKIP:   extra = OFFSET_W'(st_upd.skip_remaining);
         default:     extra = '0;
      endcase
   end

   assign rsp.found     = (st_upd.parse_mode == MODE_DONE);
   assign rsp.offset    = OFFSET_W'(pos_upd) + extra;
   assign rsp.truncated = (st_upd.parse_mode == MODE_LENGTH) ||
                          (st_upd.parse_mode == MODE_SKIP);

   // The final byte of a script leaves the parser ready for the next one.
   assign state_nxt = req.is_last ? STATE_RESET : st_upd;
   assign pos_nxt   = req.is_last ? '0 : pos_upd;

endmodule

[src/script_op_return_scanner_chk.sv]
// ----------------------------------------------------------------------------
// Script return-opcode scanner checker
// Port-level assertions on the scanner, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "script_op_return_scanner_assert.svh"

module script_op_return_scanner_chk
   import sors_pkg::*;
#(
   parameter int MAX_SCRIPT_BYTES = DEF_MAX_SCRIPT_BYTES
) (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input sors_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input sors_rsp_type rsp_data
);

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(MAX_SCRIPT_BYTES);

   // A new result only follows a final byte taken in the cycle before.
   `SORS_ASSERT(a_rsp_after_last, $rose(rsp_valid) |-> $past(req_valid && req_ready && req_data.is_last), "result without a final byte")

   // A found return never carries the truncation flag and lies within the script.
   `SORS_ASSERT(a_found_clean, rsp_valid && rsp_data.found |-> !rsp_data.truncated && rsp_data.offset != '0 && rsp_data.offset <= OFFSET_MAX, "bad found result")

   // Input back-pressure only comes from a final byte meeting a stalled result.
   `SORS_ASSERT(a_ready_cause, !req_ready |-> req_data.is_last && rsp_valid && !rsp_ready, "needless input stall")

   // A stalled result holds its payload.
   `SORS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

endmodule

bind script_op_return_scanner script_op_return_scanner_chk #(
   .MAX_SCRIPT_BYTES (MAX_SCRIPT_BYTES)
) u_chk (.*);

[tb/script_scan_checker.sv]
// ----------------------------------------------------------------------------
// Script return-opcode scanner checker
// Follows the byte stream into the scanner, keeps its own copy of the parser
// and compares each scan result with the oldest outcome still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module script_scan_checker
   import sors_pkg::*;
#(
   parameter int MAX_BYTES = DEF_MAX_SCRIPT_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  sors_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  sors_rsp_type rsp_data,
   output int           failures,
   output int           pending_results
);

   logic [MODE_W-1:0]     scan_mode;
   int unsigned           scan_pos;
   logic [SKIP_W-1:0]     skip_left;
   logic [LEN_LEFT_W-1:0] len_left;
   logic [SKIP_W-1:0]     len_value;
   logic [LEN_IDX_W-1:0]  len_index;

   sors_rsp_type scan_outcomes[$];
   int           mismatch_total = 0;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t ERROR %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_total++;
   endtask

   task automatic clear_parser();
      scan_mode = MODE_OPCODE;
      scan_pos  = 0;
      skip_left = '0;
      len_left  = '0;
      len_value = '0;
      len_index = '0;
   endtask

   // One parser step per accepted byte; the final byte of a script yields
   // the scan outcome and returns the parser to its starting state.
   task automatic parse_script_byte(input sors_req_type item);
      logic [7:0]        b;
      int unsigned       next_pos;
      longint unsigned   end_pos;
      sors_rsp_type      outcome;
      b        = item.script_byte;
      next_pos = (scan_pos < MAX_BYTES) ? scan_pos + 1 : MAX_BYTES;
      case (scan_mode)
         MODE_OPCODE: begin
            scan_pos = next_pos;
            if (b == OP_RETURN) begin
               scan_mode = MODE_DONE;
            end else if (b >= 8'd1 && b < OP_PUSH1) begin
               skip_left = SKIP_W'(b);
               scan_mode = MODE_SKIP;
            end else if (b >= OP_PUSH1 && b < OP_FIRSTOTH) begin
               len_left  = (b == OP_PUSH1) ? PUSH1_LEN_BYTES :
                           (b == OP_PUSH2) ? PUSH2_LEN_BYTES : PUSH4_LEN_BYTES;
               len_value = '0;
               len_index = '0;
               scan_mode = MODE_LENGTH;
            end
         end
         MODE_LENGTH: begin
            scan_pos  = next_pos;
            len_value = len_value | (SKIP_W'(b) << (8 * len_index));
            len_index = len_index + 1'b1;
            len_left  = len_left - 1'b1;
            if (len_left == '0) begin
               skip_left = len_value;
               scan_mode = (len_value != '0) ? MODE_SKIP : MODE_OPCODE;
            end
         end
         MODE_SKIP: begin
            scan_pos  = next_pos;
            skip_left = skip_left - 1'b1;
            if (skip_left == '0) begin
               scan_mode = MODE_OPCODE;
            end
         end
         default: begin
         end
      endcase

      if (item.is_last) begin
         end_pos           = scan_pos;
         outcome.found     = (scan_mode == MODE_DONE);
         outcome.truncated = (scan_mode == MODE_LENGTH) || (scan_mode == MODE_SKIP);
         if (scan_mode == MODE_LENGTH) begin
            end_pos = end_pos + len_left + len_value;
         end else if (scan_mode == MODE_SKIP) begin
            end_pos = end_pos + skip_left;
         end
         outcome.offset = OFFSET_W'(end_pos);
         scan_outcomes.push_back(outcome);
         clear_parser();
      end
   endtask

   always @(posedge clock) begin : watch
      sors_rsp_type want;
      if (reset) begin
         clear_parser();
         scan_outcomes.delete();
      end else begin
         // Results first: a result taken on this edge belongs to a script that
         // ended on an earlier edge.
         if (rsp_valid && rsp_ready) begin
            if (scan_outcomes.size() == 0) begin
               report_mismatch("result with no script awaiting one", rsp_data.offset, 0);
            end else begin
               want = scan_outcomes.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch("found", rsp_data.found, want.found);
               if (rsp_data.offset !== want.offset)
                  report_mismatch("offset", rsp_data.offset, want.offset);
               if (rsp_data.truncated !== want.truncated)
                  report_mismatch("truncated", rsp_data.truncated, want.truncated);
            end
         end
         if (req_valid && req_ready) begin
            parse_script_byte(req_data);
         end
      end
      pending_results <= scan_outcomes.size();
      failures        <= mismatch_total;
   end

endmodule

[tb/tb_script_op_return_scanner.sv]
// ----------------------------------------------------------------------------
// Script return-opcode scanner testbench
// Feeds directed and random scripts through the scanner with bursty input
// and a stalling result channel; a checker judges each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_script_op_return_scanner;
   import sors_pkg::*;

   localparam int MAX_BYTES    = DEF_MAX_SCRIPT_BYTES;
   // The run limit lies well above the slowest legal run (every byte behind the
   // longest sender gap, every result behind the longest stall).
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int RANDOM_BYTES = 1500;
   // The result follows in the cycle after the final byte; wait a little longer.
   localparam int DRAIN_CYCLES = 16;
   // The long result hold-off starts at this cycle and lasts this long.
   localparam int HOLD_START   = 1200;
   localparam int HOLD_CYCLES  = 300;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   sors_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   sors_rsp_type rsp_data;

   int failures;
   int pending_results;

   // Every byte of every script, in the order it is to be offered.
   sors_req_type byte_stream[$];
   int unsigned  issue_index = 0;
   int unsigned  taken_count = 0;
   int unsigned  cycle_count = 0;

   script_op_return_scanner #(
      .MAX_SCRIPT_BYTES(MAX_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   script_scan_checker #(
      .MAX_BYTES(MAX_BYTES)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .failures       (failures),
      .pending_results(pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Script construction. Bytes are appended to the stream one at a time and
   // the last byte of each script is marked once the script is complete.
   // ------------------------------------------------------------------------
   task automatic emit(input logic [7:0] value);
      sors_req_type item;
      item.script_byte = value;
      item.is_last     = 1'b0;
      byte_stream.push_back(item);
   endtask

   task automatic close_script();
      sors_req_type item;
      item         = byte_stream.pop_back();
      item.is_last = 1'b1;
      byte_stream.push_back(item);
   endtask

   // A short script given as up to eight bytes, first byte most significant.
   task automatic emit_directed(input int count, input logic [63:0] packed_bytes);
      for (int i = 0; i < count; i++) begin
         emit(packed_bytes[8*(count-1-i) +: 8]);
      end
      close_script();
   endtask

   // Any opcode that neither pushes data nor ends the scan.
   function automatic logic [7:0] plain_opcode();
      logic [7:0] op;
      do begin
         op = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(OP_FIRSTOTH, 255));
      end while (op == OP_RETURN);
      return op;
   endfunction

   // A complete push: the opcode, its little-endian length field where the
   // opcode has one, and the data itself. Data bytes are fully random, so
   // return opcodes hidden inside push data are exercised as well.
   task automatic emit_push(input logic [7:0] opcode, input int unsigned len);
      int unsigned field_bytes;
      field_bytes = (opcode == OP_PUSH1) ? 1 : (opcode == OP_PUSH2) ? 2 :
                    (opcode == OP_PUSH4) ? 4 : 0;
      emit(opcode);
      for (int i = 0; i < field_bytes; i++) begin
         emit(8'(len >> (8 * i)));
      end
      for (int i = 0; i < len; i++) begin
         emit(8'($urandom_range(0, 255)));
      end
   endtask

   // A push cut off partway through its length field or before all of its data;
   // a complete length field of zero leaves the push whole.
   task automatic emit_cut_push();
      logic [7:0]  op;
      int unsigned field_bytes;
      int unsigned len;
      int unsigned field_sent;
      case ($urandom_range(0, 3))
         0:       op = 8'($urandom_range(1, 75));
         1:       op = OP_PUSH1;
         2:       op = OP_PUSH2;
         default: op = OP_PUSH4;
      endcase
      field_bytes = (op == OP_PUSH1) ? 1 : (op == OP_PUSH2) ? 2 : (op == OP_PUSH4) ? 4 : 0;
      len = $urandom;
      if (field_bytes == 0) begin
         len = op;
      end else if (field_bytes == 1) begin
         len = len & 32'hff;
      end else if (field_bytes == 2) begin
         len = len & 32'hffff;
      end
      emit(op);
      field_sent = $urandom_range(0, field_bytes);
      for (int i = 0; i < field_sent; i++) begin
         emit(8'(len >> (8 * i)));
      end
      if (field_sent == field_bytes && len != 0) begin
         repeat ($urandom_range(0, (len - 1 < 12) ? len - 1 : 12)) begin
            emit(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Well-formed script content with no return opcode in opcode position.
   // Short pushes dominate so that scripts, and hence results, stay frequent.
   task automatic emit_body(input int unsigned target);
      int unsigned start;
      int unsigned len;
      start = byte_stream.size();
      while (byte_stream.size() - start < target) begin
         case ($urandom_range(0, 7))
            0, 1, 2: emit(plain_opcode());
            3, 4: begin
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 75) : $urandom_range(1, 6);
               emit_push(8'(len), len);
            end
            5: emit_push(OP_PUSH1, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                                                                $urandom_range(0, 4));
            6: emit_push(OP_PUSH2, ($urandom_range(0, 15) == 0) ? $urandom_range(256, 600) :
                                                                 $urandom_range(0, 4));
            default: emit_push(OP_PUSH4, $urandom_range(0, 4));
         endcase
      end
   endtask

   // Mostly well-formed scripts that end plainly, on a return opcode (with
   // some trailing bytes to be ignored) or inside a push; one in ten is noise.
   task automatic emit_random_script();
      int unsigned start;
      start = byte_stream.size();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) emit(8'($urandom_range(0, 255)));
      end else begin
         emit_body($urandom_range(0, 12));
         case ($urandom_range(0, 5))
            0, 1: begin
               if (byte_stream.size() == start) begin
                  emit(plain_opcode());
               end
            end
            2, 3: begin
               emit(OP_RETURN);
               repeat ($urandom_range(0, 4)) emit(8'($urandom_range(0, 255)));
            end
            default: emit_cut_push();
         endcase
      end
      close_script();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence: build the whole stream while reset is held, release
   // reset, then wait for the stream to be taken and every result to arrive.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned random_start;

      // Return opcode as the only byte.
      emit_directed(1, OP_RETURN);
      // Non-push opcodes only, both ends of the byte range included.
      emit_directed(3, {8'h00, OP_FIRSTOTH, 8'hff});
      // Zero-length push with a one-byte length field, then the return.
      emit_directed(3, {OP_PUSH1, 8'h00, OP_RETURN});
      // Return opcodes inside push data are skipped; the one after counts.
      emit_directed(4, {8'd2, OP_RETURN, OP_RETURN, OP_RETURN});
      // Script ends inside push data, with the smallest and largest direct push.
      emit_directed(1, 8'd75);
      emit_directed(1, 8'd1);
      // Script ends inside the length field; the missing bytes count as zero.
      emit_directed(3, {OP_PUSH4, 8'hff, 8'hff});
      // Two-byte length field, data skipped, back to opcode position.
      emit_directed(4, {OP_PUSH2, 8'h01, 8'h00, 8'h4f});
      // Zero-length push with a four-byte length field, then the return.
      emit_directed(6, {OP_PUSH4, 8'h00, 8'h00, 8'h00, 8'h00, OP_RETURN});

      random_start = byte_stream.size();
      while (byte_stream.size() - random_start < RANDOM_BYTES) begin
         emit_random_script();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (taken_count < byte_stream.size()) @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sender: offers the stream in bursts of random length separated by random
   // gaps. Long bursts give stretches with no idling at all. A new transaction
   // is only set up when the slot is empty or the current one is being taken,
   // so valid and the payload hold steady while the scanner is not ready.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : sender
      int unsigned burst_left;
      int unsigned gap_left;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            taken_count <= taken_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (issue_index < byte_stream.size()) begin
               req_valid <= 1'b1;
               req_data  <= byte_stream[issue_index];
               issue_index++;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                             $urandom_range(1, 24);
               end
               burst_left--;
               if (burst_left == 0) begin
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: switches between always ready, mostly ready and mostly stalled
   // in stretches of random length. Once, early in the random scripts, it
   // holds off for a long stretch counted here; the sender keeps offering, so
   // a finished result blocks the output register and the scanner has to
   // stall the final byte of the following script.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      int unsigned own_cycles;
      int unsigned hold_left;
      int unsigned phase_left;
      int unsigned ready_style;
      if (reset) begin
         rsp_ready   <= 1'b0;
         own_cycles  = 0;
         hold_left   = 0;
         phase_left  = 0;
         ready_style = 0;
      end else begin
         own_cycles++;
         if (own_cycles == HOLD_START) begin
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left  = $urandom_range(20, 200);
               ready_style = $urandom_range(0, 2);
            end
            phase_left--;
            case (ready_style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Run limit: a hung handshake or a missing result ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/sors_pkg.sv
src/sors_parse.sv
src/script_op_return_scanner.sv
src/script_op_return_scanner_chk.sv
tb/script_scan_checker.sv
tb/tb_script_op_return_scanner.sv
